// ----- hw/rtl/lppd_pkg.sv -----
package lppd_pkg;

    // Result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_HEADER = 2'd0;
    localparam kind_t KIND_BODY   = 2'd1;
    localparam kind_t KIND_ERROR  = 2'd2;

    // Header layout
    localparam int unsigned HDR_PACKET_BYTES = 12;
    localparam int unsigned HDR_TOTAL_BYTES  = 20;
    localparam int unsigned FUNC_HDR_BYTES   = 8;
    localparam int unsigned POS_W            = 5;

    typedef logic [POS_W-1:0] pos_t;

    // Byte offsets of the last packet-header byte and the last byte of the 20-byte header
    localparam pos_t POS_LAST_PACKET = pos_t'(HDR_PACKET_BYTES - 1);
    localparam pos_t POS_LAST_HEADER = pos_t'(HDR_TOTAL_BYTES - 1);

    // One result transaction
    typedef struct packed {
        kind_t        kind;
        logic [31:0]  content_length;
        logic [31:0]  frame_length;
        logic [15:0]  command_id;
        logic [31:0]  reserved_word;
        logic [15:0]  function_id;
        logic [7:0]   serial_number;
        logic [31:0]  function_word;
        logic [31:0]  body_length;
        logic [7:0]   body_byte;
        logic         last;
    } res_t;

endpackage

// ----- hw/rtl/length_prefixed_packet_deframer.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_stall  | stream_byte
// output   | out_valid / out_stall| kind, content_length, frame_length,
//          |                      | command_id, reserved_word, function_id,
//          |                      | serial_number, function_word, body_length,
//          |                      | body_byte, last
//
// One byte is taken every cycle while in_stall is low; its result, if any, is
// written to the output register. A second result register (skid) catches one
// result while the output is stalled; in_stall is that register's full flag.
// Reset is asynchronous and clears position, phase, body count and valids;
// the header byte store is not cleared and is always written before it is read.
module length_prefixed_packet_deframer
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           stream_byte,

    output logic                 out_valid,
    input  logic                 out_stall,
    output lppd_pkg::kind_t      kind,
    output logic [31:0]          content_length,
    output logic [31:0]          frame_length,
    output logic [15:0]          command_id,
    output logic [31:0]          reserved_word,
    output logic [15:0]          function_id,
    output logic [7:0]           serial_number,
    output logic [31:0]          function_word,
    output logic [31:0]          body_length,
    output logic [7:0]           body_byte,
    output logic                 last
);

    // State
    logic [7:0]           hdr_reg [lppd_pkg::HDR_TOTAL_BYTES];
    lppd_pkg::pos_t       pos_reg, pos_next;
    logic                 phase_reg, phase_next;
    logic [31:0]          body_rem_reg, body_rem_next;

    lppd_pkg::res_t       out_reg, skid_reg;
    logic                 out_valid_reg, skid_valid_reg;

    // Decode signals
    logic                 in_fire;
    logic                 out_fire;
    lppd_pkg::pos_t       pos_eff;
    logic [7:0]           hdr_view [lppd_pkg::HDR_TOTAL_BYTES];
    logic [31:0]          content;
    logic [31:0]          body_total;
    logic [31:0]          rem_dec;
    logic                 has_res;
    lppd_pkg::res_t       res;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    // Wrap guard on the byte position
    assign pos_eff = (pos_reg >= lppd_pkg::pos_t'(lppd_pkg::HDR_TOTAL_BYTES)) ?
                     '0 : pos_reg;

    // Header bytes with the incoming byte bypassed into its slot
    always_comb
    begin
        for (int i = 0; i < int'(lppd_pkg::HDR_TOTAL_BYTES); i++)
        begin
            if (!phase_reg && (pos_eff == lppd_pkg::pos_t'(i)))
                hdr_view[i] = stream_byte;
            else
                hdr_view[i] = hdr_reg[i];
        end
    end

    assign content    = {hdr_view[3], hdr_view[2], hdr_view[1], hdr_view[0]};
    assign body_total = content - 32'(lppd_pkg::FUNC_HDR_BYTES);
    assign rem_dec    = body_rem_reg - 32'd1;

    // Per-byte decode: next state and result
    always_comb
    begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        body_rem_next  = body_rem_reg;
        has_res        = 1'b0;

        res.kind           = lppd_pkg::KIND_HEADER;
        res.content_length = content;
        res.frame_length   = content + 32'(lppd_pkg::HDR_PACKET_BYTES);
        res.command_id     = {hdr_view[5], hdr_view[4]};
        res.reserved_word  = {hdr_view[11], hdr_view[10], hdr_view[9], hdr_view[8]};
        res.function_id    = {hdr_view[13], hdr_view[12]};
        res.serial_number  = hdr_view[14];
        res.function_word  = {hdr_view[19], hdr_view[18], hdr_view[17], hdr_view[16]};
        res.body_length    = body_total;
        res.body_byte      = 8'd0;
        res.last           = 1'b0;

        if (phase_reg)
        begin
            // Body pass-through
            has_res       = 1'b1;
            body_rem_next = rem_dec;
            res.kind      = lppd_pkg::KIND_BODY;
            res.body_byte = stream_byte;
            if (rem_dec == 32'd0)
            begin
                res.last   = 1'b1;
                phase_next = 1'b0;
                pos_next   = '0;
            end
        end
        else if ((pos_eff == lppd_pkg::POS_LAST_PACKET) && (content[31:3] == 29'd0))
        begin
            // Content below eight: error, resync on next byte
            has_res           = 1'b1;
            res.kind          = lppd_pkg::KIND_ERROR;
            res.function_id   = '0;
            res.serial_number = '0;
            res.function_word = '0;
            res.body_length   = '0;
            res.last          = 1'b1;
            pos_next          = '0;
        end
        else if (pos_eff == lppd_pkg::POS_LAST_HEADER)
        begin
            // Full header collected
            has_res  = 1'b1;
            pos_next = '0;
            if (body_total == 32'd0)
            begin
                res.last = 1'b1;
            end
            else
            begin
                phase_next    = 1'b1;
                body_rem_next = body_total;
            end
        end
        else
        begin
            pos_next = pos_eff + lppd_pkg::pos_t'(1);
        end
    end

    // Header byte store
    always_ff @(posedge clk)
    begin
        if (in_fire && !phase_reg)
            hdr_reg[pos_eff] <= stream_byte;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= 1'b0;
            body_rem_reg <= '0;
        end
        else if (in_fire)
        begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            body_rem_reg <= body_rem_next;
        end
    end

    // Output and skid valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg <= in_fire && has_res;
        end
        else if (in_fire && has_res)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (in_fire && has_res)
                out_reg <= res;
        end
        else if (in_fire && has_res)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign content_length = out_reg.content_length;
    assign frame_length   = out_reg.frame_length;
    assign command_id     = out_reg.command_id;
    assign reserved_word  = out_reg.reserved_word;
    assign function_id    = out_reg.function_id;
    assign serial_number  = out_reg.serial_number;
    assign function_word  = out_reg.function_word;
    assign body_length    = out_reg.body_length;
    assign body_byte      = out_reg.body_byte;
    assign last           = out_reg.last;

    // Assertions
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_body_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (pos_reg == '0))
        else $error("byte position not cleared during body");

    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (body_rem_reg != 32'd0))
        else $error("body phase with no bytes remaining");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == lppd_pkg::KIND_ERROR)) |-> out_reg.last)
        else $error("error transaction without last");

endmodule

// ----- tb/length_prefixed_packet_deframer_tb.sv -----
`timescale 1ns / 100ps

module length_prefixed_packet_deframer_tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Clock, reset and DUT ports
    logic              clk;
    logic              rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        stream_byte = 8'h00;

    logic              out_valid;
    logic              out_stall = 1'b0;
    lppd_pkg::kind_t   kind;
    logic [31:0]       content_length;
    logic [31:0]       frame_length;
    logic [15:0]       command_id;
    logic [31:0]       reserved_word;
    logic [15:0]       function_id;
    logic [7:0]        serial_number;
    logic [31:0]       function_word;
    logic [31:0]       body_length;
    logic [7:0]        body_byte;
    logic              last;

    length_prefixed_packet_deframer dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .content_length (content_length),
        .frame_length   (frame_length),
        .command_id     (command_id),
        .reserved_word  (reserved_word),
        .function_id    (function_id),
        .serial_number  (serial_number),
        .function_word  (function_word),
        .body_length    (body_length),
        .body_byte      (body_byte),
        .last           (last)
    );

    // Stream bytes waiting to be sent, and decoded results still owed by the DUT
    logic [7:0]        pending_bytes[$];
    lppd_pkg::res_t    expected_results[$];

    int unsigned       bytes_queued;
    int unsigned       bytes_accepted = 0;
    int unsigned       mismatches = 0;
    int unsigned       cycle_count = 0;
    int unsigned       headers_seen = 0;
    int unsigned       body_seen = 0;
    int unsigned       errors_seen = 0;

    // Deframer state mirror
    logic [7:0]        hdr_bytes [lppd_pkg::HDR_TOTAL_BYTES] = '{default: 8'h00};
    lppd_pkg::pos_t    hdr_pos = '0;
    logic              in_body = 1'b0;
    logic [31:0]       body_left = '0;

    // Idle pacing on both channels
    int unsigned       send_gap = 0;
    int unsigned       send_calm = 0;
    int unsigned       stall_left = 0;
    int unsigned       stall_calm = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly no idle, some short, a few long; occasional calm stretches
    function automatic int unsigned pick_idle(inout int unsigned calm_left);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm_left != 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        if (roll < 3)
        begin
            calm_left = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [15:0] hdr_le16(lppd_pkg::pos_t at);
        return {hdr_bytes[at + 5'd1], hdr_bytes[at]};
    endfunction

    function automatic logic [31:0] hdr_le32(lppd_pkg::pos_t at);
        return {hdr_bytes[at + 5'd3], hdr_bytes[at + 5'd2], hdr_bytes[at + 5'd1],
                hdr_bytes[at]};
    endfunction

    // Result transaction built from the gathered header bytes
    function automatic lppd_pkg::res_t frame_result(lppd_pkg::kind_t k, logic with_func,
                                                    logic [7:0] data, logic fin);
        lppd_pkg::res_t r;
        logic [31:0]    content;
        content = hdr_le32(5'd0);
        r = '0;
        r.kind = k;
        r.content_length = content;
        r.frame_length = content + 32'(lppd_pkg::HDR_PACKET_BYTES);
        r.command_id = hdr_le16(5'd4);
        r.reserved_word = hdr_le32(5'd8);
        if (with_func)
        begin
            r.function_id = hdr_le16(5'd12);
            r.serial_number = hdr_bytes[5'd14];
            r.function_word = hdr_le32(5'd16);
            r.body_length = content - 32'(lppd_pkg::FUNC_HDR_BYTES);
        end
        r.body_byte = data;
        r.last = fin;
        return r;
    endfunction

    // Advance the deframer mirror by one stream byte
    function automatic void predict_deframe(logic [7:0] b);
        lppd_pkg::pos_t p;
        logic [31:0]    content;
        if (in_body)
        begin
            body_left = body_left - 32'd1;
            if (body_left == 32'd0)
            begin
                in_body = 1'b0;
                hdr_pos = '0;
                expected_results.push_back(
                    frame_result(lppd_pkg::KIND_BODY, 1'b1, b, 1'b1));
            end
            else
                expected_results.push_back(
                    frame_result(lppd_pkg::KIND_BODY, 1'b1, b, 1'b0));
        end
        else
        begin
            p = hdr_pos;
            if (p >= lppd_pkg::pos_t'(lppd_pkg::HDR_TOTAL_BYTES))
                p = '0;
            hdr_bytes[p] = b;
            content = hdr_le32(5'd0);
            if (p == lppd_pkg::POS_LAST_PACKET && content < lppd_pkg::FUNC_HDR_BYTES)
            begin
                // short content: error, then resync on the next byte
                hdr_pos = '0;
                expected_results.push_back(
                    frame_result(lppd_pkg::KIND_ERROR, 1'b0, 8'h00, 1'b1));
            end
            else if (p == lppd_pkg::POS_LAST_HEADER)
            begin
                hdr_pos = '0;
                if (content == lppd_pkg::FUNC_HDR_BYTES)
                    expected_results.push_back(
                        frame_result(lppd_pkg::KIND_HEADER, 1'b1, 8'h00, 1'b1));
                else
                begin
                    in_body = 1'b1;
                    body_left = content - 32'(lppd_pkg::FUNC_HDR_BYTES);
                    expected_results.push_back(
                        frame_result(lppd_pkg::KIND_HEADER, 1'b1, 8'h00, 1'b0));
                end
            end
            else
                hdr_pos = p + 5'd1;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Compare one accepted output transaction with the oldest expectation
    task automatic check_result();
        lppd_pkg::res_t want;
        if (expected_results.size() == 0)
            report_mismatch($sformatf("unexpected result, kind %0d", kind));
        else
        begin
            want = expected_results.pop_front();
            check_field("kind", 32'(kind), 32'(want.kind));
            check_field("content_length", content_length, want.content_length);
            check_field("frame_length", frame_length, want.frame_length);
            check_field("command_id", 32'(command_id), 32'(want.command_id));
            check_field("reserved_word", reserved_word, want.reserved_word);
            check_field("function_id", 32'(function_id), 32'(want.function_id));
            check_field("serial_number", 32'(serial_number), 32'(want.serial_number));
            check_field("function_word", function_word, want.function_word);
            check_field("body_length", body_length, want.body_length);
            check_field("body_byte", 32'(body_byte), 32'(want.body_byte));
            check_field("last", 32'(last), 32'(want.last));
        end
    endtask

    // Stimulus builders
    task automatic queue_le16(logic [15:0] v);
        pending_bytes.push_back(v[7:0]);
        pending_bytes.push_back(v[15:8]);
    endtask

    task automatic queue_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            pending_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic queue_packet_header(logic [31:0] content, logic [15:0] cmd,
                                       logic [31:0] resv, logic [7:0] pad);
        queue_le32(content);
        queue_le16(cmd);
        pending_bytes.push_back(pad);
        pending_bytes.push_back(8'($urandom_range(0, 255)));
        queue_le32(resv);
    endtask

    task automatic queue_function_header(logic [15:0] fid, logic [7:0] serial,
                                         logic [31:0] fword, logic [7:0] pad);
        queue_le16(fid);
        pending_bytes.push_back(serial);
        pending_bytes.push_back(pad);
        queue_le32(fword);
    endtask

    task automatic queue_random_frame(logic [31:0] content, int unsigned body_bytes);
        queue_packet_header(content, 16'($urandom), $urandom, 8'($urandom));
        if (content >= lppd_pkg::FUNC_HDR_BYTES)
        begin
            queue_function_header(16'($urandom), 8'($urandom), $urandom, 8'($urandom));
            repeat (body_bytes)
                pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Driver: one byte transaction per accepted handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            stream_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_deframe(stream_byte);
                bytes_accepted = bytes_accepted + 1;
            end
            // a stalled transaction holds its byte
            if (!(in_valid && in_stall))
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap = send_gap - 1;
                end
                else if (pending_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    stream_byte <= pending_bytes.pop_front();
                    send_gap = pick_idle(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check results and apply random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                case (kind)
                    lppd_pkg::KIND_HEADER: headers_seen = headers_seen + 1;
                    lppd_pkg::KIND_BODY:   body_seen = body_seen + 1;
                    lppd_pkg::KIND_ERROR:  errors_seen = errors_seen + 1;
                    default:               ;
                endcase
                check_result();
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_idle(stall_calm);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes accepted, %0d results owed",
                     cycle_count, bytes_accepted, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned roll;
        int unsigned body_bytes;

        // Directed: short-content error with every other field all ones
        queue_packet_header(32'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        // Directed: empty body, packet fields zero, function fields all ones
        queue_packet_header(32'd8, 16'h0000, 32'h0000_0000, 8'h00);
        queue_function_header(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);

        // Random frames, mostly well formed with short bodies
        while (pending_bytes.size() < 930)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
                queue_random_frame(32'($urandom_range(0, 7)), 0);
            else if (roll < 25)
                queue_random_frame(32'd8, 0);
            else
            begin
                if ($urandom_range(0, 99) < 85)
                    body_bytes = $urandom_range(1, 24);
                else
                    body_bytes = $urandom_range(25, 160);
                queue_random_frame(32'(lppd_pkg::FUNC_HDR_BYTES + body_bytes), body_bytes);
            end
        end
        // Largest length last: frame length wraps, stream ends mid-body
        queue_random_frame(32'hFFFF_FFFF, 12);
        bytes_queued = pending_bytes.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bytes_accepted != bytes_queued)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d stream bytes in %0d cycles", bytes_accepted, cycle_count);
        $display("checked %0d headers, %0d body bytes, %0d length errors; %0d mismatches",
                 headers_seen, body_seen, errors_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lppd_pkg.sv
hw/rtl/length_prefixed_packet_deframer.sv
tb/length_prefixed_packet_deframer_tb.sv
